// ----- design/cfp_pkg.sv -----
// cfp_pkg: shared types, constants and the CRC byte step of the frame parser.
// No dependencies; imported by cfp_ctrl, cfp_dp and crc32_frame_parser.
package cfp_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int CRC_BYTES    = 4;
    localparam int RESULT_LIMIT = 64;

    // header byte offsets from the frame start
    localparam int OFF_VER    = 2;
    localparam int OFF_CMD    = 3;
    localparam int OFF_SEQ_LO = 4;
    localparam int OFF_SEQ_HI = 5;
    localparam int OFF_LEN_LO = 6;
    localparam int OFF_LEN_HI = 7;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_START_FIRST  = 3'd0;
    localparam t_cfg_idx REG_START_SECOND = 3'd1;
    localparam t_cfg_idx REG_VERSION      = 3'd2;
    localparam t_cfg_idx REG_GAP_TIMEOUT  = 3'd3;

    typedef logic [1:0] t_item_kind;
    localparam t_item_kind KIND_PAYLOAD = 2'd0;
    localparam t_item_kind KIND_EMPTY   = 2'd1;
    localparam t_item_kind KIND_STATUS  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_F0, ST_U0,
        ST_F1, ST_U1,
        ST_FH, ST_UH,
        ST_LCHK,
        ST_FP, ST_UP,
        ST_FC, ST_UC,
        ST_CCHK,
        ST_FE, ST_UE,
        ST_EMPTY,
        ST_DONE,
        ST_STAT
    } t_state;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_BODY
    } t_idx_op;

    typedef struct packed {
        logic       accept;
        t_idx_op    idx_op;
        logic       crc_init;
        logic       hdr_cap;
        logic       crc_upd;
        logic       rx_shift;
        logic       drop_one;
        logic       drop_frame;
        logic       cnt_len;
        logic       cnt_crc;
        logic       cnt_ver;
        logic       cnt_frame;
        logic       emit;
        t_item_kind emit_kind;
    } t_cmd;

    typedef struct packed {
        logic in_kind;
        logic fill_zero;
        logic first_ok;
        logic second_ok;
        logic fill_lt2;
        logic fill_lt8;
        logic len_big;
        logic frame_short;
        logic len_zero;
        logic hdr_end;
        logic pay_end;
        logic crc_end;
        logic crc_ok;
        logic ver_ok;
        logic k_room;
        logic out_free;
    } t_sts;

    // one byte of reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
        end
        return x;
    endfunction

endpackage

// ----- design/cfp_in_if.sv -----
// cfp_in_if: request channel into the frame parser (received byte or time poll).
// Depends on nothing.
interface cfp_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] now_ms;

    modport source (output valid, output kind, output data_byte, output now_ms, input ready);
    modport sink   (input valid, input kind, input data_byte, input now_ms, output ready);
endinterface

// ----- design/cfp_out_if.sv -----
// cfp_out_if: result channel of the frame parser (payload, empty frame, status).
// Depends on nothing.
interface cfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  command;
    logic [15:0] sequence_res;
    logic [5:0]  frame_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] frames_count;
    logic [31:0] timeouts_count;
    logic [31:0] length_error_count;
    logic [31:0] crc_error_count;
    logic [31:0] version_error_count;

    modport source (output valid, output item_kind, output command, output sequence_res,
                    output frame_length, output payload_byte, output last,
                    output frames_count, output timeouts_count, output length_error_count,
                    output crc_error_count, output version_error_count, input ready);
    modport sink   (input valid, input item_kind, input command, input sequence_res,
                    input frame_length, input payload_byte, input last,
                    input frames_count, input timeouts_count, input length_error_count,
                    input crc_error_count, input version_error_count, output ready);
endinterface

// ----- design/cfp_ram.sv -----
// cfp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/cfp_ctrl.sv -----
// cfp_ctrl: scan sequencer of the frame parser; drives datapath commands.
// Depends on cfp_pkg.
module cfp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cfp_pkg::t_sts i_sts,
    output cfp_pkg::t_cmd o_cmd
);
    import cfp_pkg::*;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = i_sts.in_kind ? ST_STAT : ST_SCAN;
            ST_SCAN:  n_state = i_sts.fill_zero ? ST_STAT : ST_F0;
            ST_F0:    n_state = ST_U0;
            ST_U0: begin
                if (!i_sts.first_ok)     n_state = ST_SCAN;
                else if (i_sts.fill_lt2) n_state = ST_STAT;
                else                     n_state = ST_F1;
            end
            ST_F1:    n_state = ST_U1;
            ST_U1: begin
                if (!i_sts.second_ok)    n_state = ST_SCAN;
                else if (i_sts.fill_lt8) n_state = ST_STAT;
                else                     n_state = ST_FH;
            end
            ST_FH:    n_state = ST_UH;
            ST_UH:    n_state = i_sts.hdr_end ? ST_LCHK : ST_FH;
            ST_LCHK: begin
                if (i_sts.len_big)          n_state = ST_SCAN;
                else if (i_sts.frame_short) n_state = ST_STAT;
                else if (i_sts.len_zero)    n_state = ST_FC;
                else                        n_state = ST_FP;
            end
            ST_FP:    n_state = ST_UP;
            ST_UP:    n_state = i_sts.pay_end ? ST_FC : ST_FP;
            ST_FC:    n_state = ST_UC;
            ST_UC:    n_state = i_sts.crc_end ? ST_CCHK : ST_FC;
            ST_CCHK: begin
                if (!i_sts.crc_ok || !i_sts.ver_ok) n_state = ST_SCAN;
                else if (i_sts.len_zero)            n_state = ST_EMPTY;
                else                                n_state = ST_FE;
            end
            ST_FE:    n_state = ST_UE;
            ST_UE: begin
                if (!i_sts.k_room || i_sts.out_free) begin
                    n_state = i_sts.pay_end ? ST_DONE : ST_FE;
                end
            end
            ST_EMPTY: if (!i_sts.k_room || i_sts.out_free) n_state = ST_DONE;
            ST_DONE:  n_state = ST_SCAN;
            ST_STAT:  if (i_sts.out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        cmd.idx_op = IDX_HOLD;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                cmd.accept = i_in_valid;
            end
            ST_SCAN:  cmd.idx_op = IDX_ZERO;
            ST_U0: begin
                if (!i_sts.first_ok)      cmd.drop_one = 1'b1;
                else if (!i_sts.fill_lt2) cmd.idx_op   = IDX_INC;
            end
            ST_U1: begin
                if (!i_sts.second_ok) begin
                    cmd.drop_one = 1'b1;
                end else if (!i_sts.fill_lt8) begin
                    cmd.idx_op   = IDX_INC;
                    cmd.crc_init = 1'b1;
                end
            end
            ST_UH: begin
                cmd.hdr_cap = 1'b1;
                if (!i_sts.hdr_end) cmd.idx_op = IDX_INC;
            end
            ST_LCHK: begin
                if (i_sts.len_big) begin
                    cmd.cnt_len  = 1'b1;
                    cmd.drop_one = 1'b1;
                end else if (!i_sts.frame_short) begin
                    cmd.idx_op = IDX_INC;
                end
            end
            ST_UP: begin
                cmd.crc_upd = 1'b1;
                cmd.idx_op  = IDX_INC;
            end
            ST_UC: begin
                cmd.rx_shift = 1'b1;
                if (!i_sts.crc_end) cmd.idx_op = IDX_INC;
            end
            ST_CCHK: begin
                if (!i_sts.crc_ok) begin
                    cmd.cnt_crc  = 1'b1;
                    cmd.drop_one = 1'b1;
                end else if (!i_sts.ver_ok) begin
                    cmd.cnt_ver    = 1'b1;
                    cmd.drop_frame = 1'b1;
                end else begin
                    cmd.idx_op = IDX_BODY;
                end
            end
            ST_UE: begin
                if (!i_sts.k_room || i_sts.out_free) begin
                    cmd.emit      = i_sts.k_room;
                    cmd.emit_kind = KIND_PAYLOAD;
                    if (!i_sts.pay_end) cmd.idx_op = IDX_INC;
                end
            end
            ST_EMPTY: begin
                cmd.emit      = i_sts.k_room && i_sts.out_free;
                cmd.emit_kind = KIND_EMPTY;
            end
            ST_DONE: begin
                cmd.drop_frame = 1'b1;
                cmd.cnt_frame  = 1'b1;
            end
            ST_STAT: begin
                cmd.emit      = i_sts.out_free;
                cmd.emit_kind = KIND_STATUS;
            end
            default: ;
        endcase
    end

    assign o_cmd = cmd;
endmodule

// ----- design/cfp_dp.sv -----
// cfp_dp: datapath of the frame parser: circular frame store, header and CRC
// registers, event counters, configuration and the result register.
// Depends on cfp_pkg, cfp_ram, cfp_in_if and cfp_out_if.
module cfp_dp #(
    parameter int MAX_PAYLOAD_BYTES = 48,
    parameter int STORE_DEPTH       = 60
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  cfp_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [cfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfp_in_if.sink                    i_in,
    cfp_out_if.source                 o_out,
    input  cfp_pkg::t_cmd             i_cmd,
    output cfp_pkg::t_sts             o_sts
);
    import cfp_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int KW = $clog2(RESULT_LIMIT + 1);
    localparam int LW = 17;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
        return (s >= (AW+1)'(STORE_DEPTH)) ? AW'(s - (AW+1)'(STORE_DEPTH)) : AW'(s);
    endfunction

    // configuration
    logic [7:0]  r_sof1, r_sof2, r_acc_ver;
    logic [15:0] r_gap;

    // store control
    logic [AW-1:0] r_head, r_idx;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_last;

    // frame fields
    logic [7:0]  r_ver, r_cmd;
    logic [15:0] r_seq, r_len;
    logic [31:0] r_crc, r_rx;
    logic [KW-1:0] r_k;

    logic [31:0] r_frames, r_touts, r_lenerr, r_crcerr, r_vererr;

    // result register
    logic        r_ov;
    t_item_kind  r_o_kind;
    logic [7:0]  r_o_cmd, r_o_pb;
    logic [15:0] r_o_seq;
    logic [5:0]  r_o_len;
    logic        r_o_last;
    logic [31:0] r_o_frames, r_o_touts, r_o_lenerr, r_o_crcerr, r_o_vererr;

    logic          timed_out, full;
    logic [FW-1:0] fill_t, fill_f;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;
    logic          we;
    logic [FW-1:0] frame_bytes;
    logic          out_free;

    assign timed_out = (r_fill != '0) && ((i_in.now_ms - r_last) >= {16'd0, r_gap});
    assign fill_t    = timed_out ? '0 : r_fill;
    assign full      = fill_t >= FW'(STORE_DEPTH);
    assign fill_f    = full ? '0 : fill_t;
    assign we        = i_cmd.accept && !i_in.kind;
    assign waddr     = wrap({1'b0, r_head} + (AW+1)'(fill_f));
    assign raddr     = wrap({1'b0, r_head} + {1'b0, r_idx});
    assign frame_bytes = FW'(r_len) + FW'(HEADER_BYTES + CRC_BYTES);
    assign out_free  = !r_ov || o_out.ready;

    cfp_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in.data_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sof1    <= 8'd170;
            r_sof2    <= 8'd85;
            r_acc_ver <= 8'd1;
            r_gap     <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_FIRST:  r_sof1    <= i_cfg_data[7:0];
                REG_START_SECOND: r_sof2    <= i_cfg_data[7:0];
                REG_VERSION:      r_acc_ver <= i_cfg_data[7:0];
                REG_GAP_TIMEOUT:  r_gap     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_fill   <= '0;
            r_last   <= '0;
            r_idx    <= '0;
            r_k      <= '0;
            r_frames <= '0;
            r_touts  <= '0;
            r_lenerr <= '0;
            r_crcerr <= '0;
            r_vererr <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_k <= '0;
                if (timed_out) r_touts <= r_touts + 32'd1;
                if (!i_in.kind) begin
                    if (full) r_lenerr <= r_lenerr + 32'd1;
                    r_fill <= fill_f + FW'(1);
                    r_last <= i_in.now_ms;
                end else begin
                    r_fill <= fill_t;
                end
            end
            if (i_cmd.drop_one) begin
                r_head <= wrap({1'b0, r_head} + (AW+1)'(1));
                r_fill <= r_fill - FW'(1);
            end
            if (i_cmd.drop_frame) begin
                r_head <= wrap({1'b0, r_head} + (AW+1)'(frame_bytes));
                r_fill <= r_fill - frame_bytes;
            end
            unique case (i_cmd.idx_op)
                IDX_HOLD: ;
                IDX_ZERO: r_idx <= '0;
                IDX_INC:  r_idx <= r_idx + AW'(1);
                IDX_BODY: r_idx <= AW'(HEADER_BYTES);
                default: ;
            endcase
            if (i_cmd.cnt_len)   r_lenerr <= r_lenerr + 32'd1;
            if (i_cmd.cnt_crc)   r_crcerr <= r_crcerr + 32'd1;
            if (i_cmd.cnt_ver)   r_vererr <= r_vererr + 32'd1;
            if (i_cmd.cnt_frame) r_frames <= r_frames + 32'd1;
            if (i_cmd.emit && i_cmd.emit_kind != KIND_STATUS) r_k <= r_k + KW'(1);
        end
    end

    // header capture, CRC and received CRC
    always_ff @(posedge i_clk) begin
        if (i_cmd.crc_init) r_crc <= CRC_INIT;
        if (i_cmd.hdr_cap || i_cmd.crc_upd) r_crc <= crc_byte(r_crc, rdata);
        if (i_cmd.rx_shift) r_rx <= {rdata, r_rx[31:8]};
        if (i_cmd.hdr_cap) begin
            case (r_idx)
                AW'(OFF_VER):    r_ver        <= rdata;
                AW'(OFF_CMD):    r_cmd        <= rdata;
                AW'(OFF_SEQ_LO): r_seq[7:0]   <= rdata;
                AW'(OFF_SEQ_HI): r_seq[15:8]  <= rdata;
                AW'(OFF_LEN_LO): r_len[7:0]   <= rdata;
                AW'(OFF_LEN_HI): r_len[15:8]  <= rdata;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_kind   <= i_cmd.emit_kind;
            r_o_last   <= (i_cmd.emit_kind == KIND_STATUS);
            r_o_cmd    <= '0;
            r_o_seq    <= '0;
            r_o_len    <= '0;
            r_o_pb     <= '0;
            r_o_frames <= '0;
            r_o_touts  <= '0;
            r_o_lenerr <= '0;
            r_o_crcerr <= '0;
            r_o_vererr <= '0;
            unique case (i_cmd.emit_kind)
                KIND_PAYLOAD: begin
                    r_o_cmd <= r_cmd;
                    r_o_seq <= r_seq;
                    r_o_len <= r_len[5:0];
                    r_o_pb  <= rdata;
                end
                KIND_EMPTY: begin
                    r_o_cmd <= r_cmd;
                    r_o_seq <= r_seq;
                end
                KIND_STATUS: begin
                    r_o_frames <= r_frames;
                    r_o_touts  <= r_touts;
                    r_o_lenerr <= r_lenerr;
                    r_o_crcerr <= r_crcerr;
                    r_o_vererr <= r_vererr;
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid               = r_ov;
    assign o_out.item_kind           = r_o_kind;
    assign o_out.command             = r_o_cmd;
    assign o_out.sequence_res        = r_o_seq;
    assign o_out.frame_length        = r_o_len;
    assign o_out.payload_byte        = r_o_pb;
    assign o_out.last                = r_o_last;
    assign o_out.frames_count        = r_o_frames;
    assign o_out.timeouts_count      = r_o_touts;
    assign o_out.length_error_count  = r_o_lenerr;
    assign o_out.crc_error_count     = r_o_crcerr;
    assign o_out.version_error_count = r_o_vererr;

    always_comb begin
        o_sts             = '0;
        o_sts.in_kind     = i_in.kind;
        o_sts.fill_zero   = (r_fill == '0);
        o_sts.first_ok    = (rdata == r_sof1);
        o_sts.second_ok   = (rdata == r_sof2);
        o_sts.fill_lt2    = (r_fill < FW'(2));
        o_sts.fill_lt8    = (r_fill < FW'(HEADER_BYTES));
        o_sts.len_big     = (r_len > 16'(MAX_PAYLOAD_BYTES));
        o_sts.frame_short = (LW'(r_fill) < (LW'(r_len) + LW'(HEADER_BYTES + CRC_BYTES)));
        o_sts.len_zero    = (r_len == '0);
        o_sts.hdr_end     = (r_idx == AW'(HEADER_BYTES - 1));
        o_sts.pay_end     = (r_idx == AW'(r_len) + AW'(HEADER_BYTES - 1));
        o_sts.crc_end     = (r_idx == AW'(r_len) + AW'(HEADER_BYTES + CRC_BYTES - 1));
        o_sts.crc_ok      = ((r_crc ^ CRC_INIT) == r_rx);
        o_sts.ver_ok      = (r_ver == r_acc_ver);
        o_sts.k_room      = (r_k < KW'(RESULT_LIMIT - 1));
        o_sts.out_free    = out_free;
    end
endmodule

// ----- design/crc32_frame_parser.sv -----
// crc32_frame_parser: top level of the serial frame parser with CRC-32 check.
// Depends on cfp_pkg, cfp_in_if, cfp_out_if, cfp_ctrl, cfp_dp.
//
//   channel   dir   handshake        carries
//   i_in      in    valid/ready      kind, data_byte, now_ms
//   o_out     out   valid/ready      item_kind ... version_error_count
//   i_cfg_*   in    write enable     register index, data (16 bits)
//
// One request at a time: a time poll goes straight to the status result; a byte
// starts a rescan that reads bytes back from the store (header, payload, CRC and
// once more per delivered payload byte) through the single read port of the store.
// Synchronous active-low reset clears control state and counters; the store
// needs no clearing. A stalled result register holds the sequencer where it emits.
module crc32_frame_parser #(
    parameter int MAX_PAYLOAD_BYTES = 48,
    parameter int STORE_DEPTH       = 60
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  cfp_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [cfp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfp_in_if.sink                        i_in,
    cfp_out_if.source                     o_out
);
    import cfp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign i_in.ready = w_ready;

    cfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cfp_dp #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
        .STORE_DEPTH       (STORE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );
endmodule
